>>> src/agwu_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_pkg: shared types, constants and fixed-point helpers
// Q8.24 constants, pipeline geometry and request/response records for the
// adaptive gain weight update engine.
// -----------------------------------------------------------------------------
package agwu_pkg;

   // Weight store geometry (power of two, 16 .. 2^20)
   localparam int NUM_WEIGHTS = 65536;
   localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

   // Configuration registers
   localparam int CFG_W = 25;
   localparam logic [CFG_W-1:0] LR_RESET  = 25'd16777;
   localparam logic [CFG_W-1:0] MOM_RESET = 25'd15099494;
   localparam logic CSR_LEARNING_RATE = 1'b0;
   localparam logic CSR_MOMENTUM_COEF = 1'b1;

   // Commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Q0.24 / Q8.24 constants
   localparam logic [23:0]        K_090    = 24'd15099494;
   localparam logic [23:0]        K_010    = 24'd1677722;
   localparam logic [23:0]        K_095    = 24'd15938355;
   localparam logic signed [31:0] K_005    = 32'sd838861;
   localparam logic signed [31:0] ONE_Q24  = 32'sh0100_0000;
   localparam logic [63:0]        HALF_Q24 = 64'd8388608;
   localparam logic [63:0]        SQ_MAX   = 64'd2147483647;

   localparam logic signed [65:0] MAX32 = 66'sd2147483647;
   localparam logic signed [65:0] MIN32 = -MAX32 - 66'sd1;

   // Square root: radicand is (rms + 1) << 24, 56 bits, two bits a step
   localparam int ROOT_W     = 28;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int SQ_REM_W   = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;

   // Division: (|g| << 24 + s/2) / s, one quotient bit a step
   localparam int QUO_W     = 32;
   localparam int DEN_W     = ROOT_W;
   localparam int NUM_W     = 56;
   localparam int DIV_STEPS = QUO_W;

   // Back pipeline: issue, four arithmetic stages, sqrt, numerator, divide,
   // quotient, product, change
   localparam int PIPE_DEPTH = 5 + SQRT_STEPS + 1 + DIV_STEPS + 3;

   // Request queue
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
   localparam logic [FQ_PTR_W-1:0] FQ_LAST = FQ_PTR_W'(FQ_DEPTH - 1);
   localparam logic [FQ_CNT_W-1:0] FQ_FULL = FQ_CNT_W'(FQ_DEPTH);

   // Response queue
   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
   localparam logic [OQ_PTR_W-1:0] OQ_LAST = OQ_PTR_W'(OQ_DEPTH - 1);
   localparam logic [OQ_CNT_W-1:0] OQ_FULL = OQ_CNT_W'(OQ_DEPTH);

   typedef struct packed {
      logic                    cmd;
      logic [ADDR_W-1:0]       addr;
      logic signed [31:0]      operand;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]       addr;
      logic signed [31:0]      weight;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] weight;
      logic signed [31:0] rms;
      logic signed [31:0] gain;
      logic signed [31:0] change;
   } entry_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] operand;
      logic [31:0]        gmag;
      logic signed [31:0] weight;
      logic signed [31:0] gain;
      logic signed [31:0] prev;
      logic signed [31:0] rms;
      logic signed [31:0] ag;
      logic signed [31:0] g95;
      logic signed [57:0] mp;
      logic               ovf;
   } pay_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > MAX32) begin
         r = MAX32[31:0];
      end else if (v < MIN32) begin
         r = MIN32[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // v / 2^24, round half away from zero, then saturate
   function automatic logic signed [31:0] rescale_sat(input logic signed [65:0] v);
      logic [65:0]        mag;
      logic [65:0]        rnd;
      logic signed [65:0] res;
      mag = v[65] ? 66'(-v) : 66'(v);
      rnd = (mag + 66'd8388608) >> 24;
      res = v[65] ? -$signed(rnd) : $signed(rnd);
      return sat32(res);
   endfunction

   function automatic logic [ADDR_W-1:0] eff_addr(input logic [15:0] idx);
      logic [31:0] t;
      t = 32'(idx);
      return t[ADDR_W-1:0];
   endfunction

   function automatic logic [15:0] to_index(input logic [ADDR_W-1:0] a);
      logic [31:0] t;
      t = 32'(a);
      return t[15:0];
   endfunction

endpackage

>>> src/agwu_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_front: request intake
// Maps the index onto the store and holds requests in a short queue until the
// back pipeline issues them.
// -----------------------------------------------------------------------------
module agwu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_cmd,
   input  logic [15:0]           req_index,
   input  logic signed [31:0]    req_operand_value,
   output logic                  head_vld,
   output agwu_pkg::req_type     head,
   input  logic                  take
);

   agwu_pkg::req_type                  slot_ff [agwu_pkg::FQ_DEPTH];
   logic [agwu_pkg::FQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [agwu_pkg::FQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [agwu_pkg::FQ_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                               do_push;
   agwu_pkg::req_type                  new_req;

   assign full     = (cnt_ff == agwu_pkg::FQ_FULL);
   assign head_vld = (cnt_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;

   always_comb begin
      new_req.cmd     = req_cmd;
      new_req.addr    = agwu_pkg::eff_addr(req_index);
      new_req.operand = req_operand_value;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == agwu_pkg::FQ_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == agwu_pkg::FQ_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_req;
      end
   end

endmodule

>>> src/agwu_sqrt.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, with side payload.
// -----------------------------------------------------------------------------
module agwu_sqrt (
   input  logic                            clock,
   input  logic                            en,
   input  logic [agwu_pkg::RAD_W-1:0]      radicand,
   input  agwu_pkg::pay_type               in_pay,
   output logic [agwu_pkg::ROOT_W-1:0]     root,
   output agwu_pkg::pay_type               out_pay
);

   logic [agwu_pkg::SQ_REM_W-1:0] rem_ff  [agwu_pkg::SQRT_STEPS];
   logic [agwu_pkg::SQ_REM_W-1:0] rem_in  [agwu_pkg::SQRT_STEPS];
   logic [agwu_pkg::ROOT_W-1:0]   root_ff [agwu_pkg::SQRT_STEPS];
   logic [agwu_pkg::ROOT_W-1:0]   root_in [agwu_pkg::SQRT_STEPS];
   logic [agwu_pkg::RAD_W-1:0]    rad_ff  [agwu_pkg::SQRT_STEPS];
   logic [agwu_pkg::RAD_W-1:0]    rad_in  [agwu_pkg::SQRT_STEPS];
   agwu_pkg::pay_type             pay_ff  [agwu_pkg::SQRT_STEPS];
   agwu_pkg::pay_type             pay_in  [agwu_pkg::SQRT_STEPS];

   always_comb begin
      logic [agwu_pkg::SQ_REM_W-1:0] prv_rem;
      logic [agwu_pkg::ROOT_W-1:0]   prv_root;
      logic [agwu_pkg::RAD_W-1:0]    prv_rad;
      logic [agwu_pkg::SQ_REM_W+1:0] cur;
      logic [agwu_pkg::SQ_REM_W+1:0] trial;
      logic [agwu_pkg::SQ_REM_W+1:0] diff;
      for (int k = 0; k < agwu_pkg::SQRT_STEPS; k++) begin
         if (k == 0) begin
            prv_rem   = '0;
            prv_root  = '0;
            prv_rad   = radicand;
            pay_in[k] = in_pay;
         end else begin
            prv_rem   = rem_ff[k-1];
            prv_root  = root_ff[k-1];
            prv_rad   = rad_ff[k-1];
            pay_in[k] = pay_ff[k-1];
         end
         cur   = {prv_rem, prv_rad[agwu_pkg::RAD_W-1 -: 2]};
         trial = {2'b00, prv_root, 2'b01};
         diff  = cur - trial;
         if (cur >= trial) begin
            rem_in[k]  = diff[agwu_pkg::SQ_REM_W-1:0];
            root_in[k] = {prv_root[agwu_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[agwu_pkg::SQ_REM_W-1:0];
            root_in[k] = {prv_root[agwu_pkg::ROOT_W-2:0], 1'b0};
         end
         rad_in[k] = {prv_rad[agwu_pkg::RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < agwu_pkg::SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            pay_ff[k]  <= pay_in[k];
         end
      end
   end

   assign root    = root_ff[agwu_pkg::SQRT_STEPS-1];
   assign out_pay = pay_ff[agwu_pkg::SQRT_STEPS-1];

endmodule

>>> src/agwu_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, low 32 quotient bits only;
// the caller flags quotients that do not fit.
// -----------------------------------------------------------------------------
module agwu_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [agwu_pkg::NUM_W-1:0]     num,
   input  logic [agwu_pkg::DEN_W-1:0]     den,
   input  agwu_pkg::pay_type              in_pay,
   output logic [agwu_pkg::QUO_W-1:0]     quo,
   output agwu_pkg::pay_type              out_pay
);

   logic [agwu_pkg::DEN_W-1:0] rem_ff  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::DEN_W-1:0] rem_in  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::QUO_W-1:0] quo_ff  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::QUO_W-1:0] quo_in  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::QUO_W-1:0] low_ff  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::QUO_W-1:0] low_in  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::DEN_W-1:0] den_ff  [agwu_pkg::DIV_STEPS];
   logic [agwu_pkg::DEN_W-1:0] den_in  [agwu_pkg::DIV_STEPS];
   agwu_pkg::pay_type          pay_ff  [agwu_pkg::DIV_STEPS];
   agwu_pkg::pay_type          pay_in  [agwu_pkg::DIV_STEPS];

   always_comb begin
      logic [agwu_pkg::DEN_W-1:0] prv_rem;
      logic [agwu_pkg::QUO_W-1:0] prv_quo;
      logic [agwu_pkg::QUO_W-1:0] prv_low;
      logic [agwu_pkg::DEN_W:0]   cur;
      logic [agwu_pkg::DEN_W:0]   diff;
      for (int k = 0; k < agwu_pkg::DIV_STEPS; k++) begin
         if (k == 0) begin
            prv_rem   = {{(agwu_pkg::DEN_W - agwu_pkg::NUM_W + agwu_pkg::QUO_W){1'b0}},
                         num[agwu_pkg::NUM_W-1:agwu_pkg::QUO_W]};
            prv_quo   = '0;
            prv_low   = num[agwu_pkg::QUO_W-1:0];
            den_in[k] = den;
            pay_in[k] = in_pay;
         end else begin
            prv_rem   = rem_ff[k-1];
            prv_quo   = quo_ff[k-1];
            prv_low   = low_ff[k-1];
            den_in[k] = den_ff[k-1];
            pay_in[k] = pay_ff[k-1];
         end
         cur  = {prv_rem, prv_low[agwu_pkg::QUO_W-1]};
         diff = cur - {1'b0, den_in[k]};
         if (cur >= {1'b0, den_in[k]}) begin
            rem_in[k] = diff[agwu_pkg::DEN_W-1:0];
            quo_in[k] = {prv_quo[agwu_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = cur[agwu_pkg::DEN_W-1:0];
            quo_in[k] = {prv_quo[agwu_pkg::QUO_W-2:0], 1'b0};
         end
         low_in[k] = {prv_low[agwu_pkg::QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < agwu_pkg::DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
            pay_ff[k] <= pay_in[k];
         end
      end
   end

   assign quo     = quo_ff[agwu_pkg::DIV_STEPS-1];
   assign out_pay = pay_ff[agwu_pkg::DIV_STEPS-1];

endmodule

>>> src/agwu_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_back: update pipeline and per-weight store
// Issues queued requests, reads the stored entry, runs the RMS / root / divide /
// momentum arithmetic and writes the entry back at the last stage.
// -----------------------------------------------------------------------------
module agwu_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [agwu_pkg::CFG_W-1:0]     learning_rate,
   input  logic [agwu_pkg::CFG_W-1:0]     momentum_coef,
   input  logic                           head_vld,
   input  agwu_pkg::req_type              head,
   output logic                           take,
   input  logic                           out_full,
   output logic                           rsp_vld,
   output agwu_pkg::rsp_type              rsp
);

   localparam int LAST = agwu_pkg::PIPE_DEPTH - 1;

   // In-flight tracker: valid and address of every stage
   logic [agwu_pkg::PIPE_DEPTH-1:0]  vld_ff;
   logic [agwu_pkg::ADDR_W-1:0]      adr_ff [agwu_pkg::PIPE_DEPTH];
   logic                             adv;
   logic                             hazard;

   agwu_pkg::entry_type              store_mem [agwu_pkg::NUM_WEIGHTS];
   agwu_pkg::entry_type              rd_ff;
   agwu_pkg::entry_type              wr_data;
   logic                             wr_en;

   logic                             s0_cmd_ff;
   logic signed [31:0]               s0_opnd_ff;

   agwu_pkg::pay_type                s1_pay_ff, s1_pay_in;
   logic [63:0]                      s1_gsq_ff, s1_gsq_in;
   logic signed [56:0]               s1_p90_ff, s1_p90_in;
   logic signed [57:0]               s1_agp_ff, s1_agp_in;
   logic signed [56:0]               s1_g95p_ff, s1_g95p_in;

   agwu_pkg::pay_type                s2_pay_ff, s2_pay_in;
   logic [30:0]                      s2_sq_ff, s2_sq_in;
   logic signed [56:0]               s2_p90_ff;

   agwu_pkg::pay_type                s3_pay_ff;
   logic [54:0]                      s3_p10_ff, s3_p10_in;
   logic signed [56:0]               s3_p90_ff;

   agwu_pkg::pay_type                s4_pay_ff, s4_pay_in;
   logic [agwu_pkg::RAD_W-1:0]       rad;

   logic [agwu_pkg::ROOT_W-1:0]      sq_root;
   agwu_pkg::pay_type                sq_pay;

   agwu_pkg::pay_type                sn_pay_ff, sn_pay_in;
   logic [agwu_pkg::NUM_W-1:0]       sn_num_ff, sn_num_in;
   logic [agwu_pkg::DEN_W-1:0]       sn_den_ff;

   logic [agwu_pkg::QUO_W-1:0]       dv_quo;
   agwu_pkg::pay_type                dv_pay;

   agwu_pkg::pay_type                se_pay_ff;
   logic signed [31:0]               se_nq_ff, se_nq_in;

   agwu_pkg::pay_type                sf_pay_ff;
   logic signed [63:0]               sf_prod_ff, sf_prod_in;

   agwu_pkg::pay_type                sg_pay_ff;
   logic signed [31:0]               sg_chg_ff, sg_chg_in;

   logic signed [31:0]               fin_weight;
   logic signed [31:0]               fin_gain;

   // ---------------- issue and hazard ----------------
   assign adv   = !vld_ff[LAST] || !out_full;
   assign wr_en = vld_ff[LAST] && !out_full;
   assign take  = head_vld && adv && !hazard;

   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < agwu_pkg::PIPE_DEPTH; k++) begin
         if (vld_ff[k] && (adr_ff[k] == head.addr)) begin
            hazard = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[agwu_pkg::PIPE_DEPTH-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         adr_ff[0] <= head.addr;
         for (int k = 1; k < agwu_pkg::PIPE_DEPTH; k++) begin
            adr_ff[k] <= adr_ff[k-1];
         end
      end
   end

   // ---------------- store ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= store_mem[head.addr];
      end
      if (wr_en) begin
         store_mem[adr_ff[LAST]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_cmd_ff  <= head.cmd;
         s0_opnd_ff <= head.operand;
      end
   end

   // ---------------- stage 1: products ----------------
   always_comb begin
      logic [31:0] gmag;
      gmag = s0_opnd_ff[31] ? -s0_opnd_ff : s0_opnd_ff;
      s1_pay_in         = '0;
      s1_pay_in.cmd     = s0_cmd_ff;
      s1_pay_in.operand = s0_opnd_ff;
      s1_pay_in.gmag    = gmag;
      s1_pay_in.weight  = rd_ff.weight;
      s1_pay_in.gain    = rd_ff.gain;
      s1_pay_in.prev    = rd_ff.change;
      s1_pay_in.mp      = 58'($signed({1'b0, momentum_coef})) * 58'(rd_ff.change);
      s1_gsq_in         = 64'(gmag) * 64'(gmag);
      s1_p90_in  = 57'($signed({1'b0, agwu_pkg::K_090})) * 57'(rd_ff.rms);
      s1_agp_in  = 58'($signed({1'b0, learning_rate})) * 58'(rd_ff.gain);
      s1_g95p_in = 57'($signed({1'b0, agwu_pkg::K_095})) * 57'(rd_ff.gain);
   end

   // ---------------- stage 2: rescale ----------------
   always_comb begin
      logic [63:0] sh;
      sh = (s1_gsq_ff + agwu_pkg::HALF_Q24) >> 24;
      s2_sq_in = (sh > agwu_pkg::SQ_MAX) ? 31'h7fff_ffff : sh[30:0];
      s2_pay_in     = s1_pay_ff;
      s2_pay_in.ag  = agwu_pkg::rescale_sat(66'(s1_agp_ff));
      s2_pay_in.g95 = agwu_pkg::rescale_sat(66'(s1_g95p_ff));
   end

   // ---------------- stage 3 / 4: mean square ----------------
   assign s3_p10_in = 55'(agwu_pkg::K_010) * 55'(s2_sq_ff);

   always_comb begin
      logic signed [57:0] acc;
      acc = 58'(s3_p90_ff) + $signed({3'b000, s3_p10_ff});
      s4_pay_in     = s3_pay_ff;
      s4_pay_in.rms = acc[57] ? '0 : agwu_pkg::rescale_sat(66'(acc));
   end

   // radicand (rms + 1) << 24, rms already non-negative
   always_comb begin
      logic [30:0] d;
      d   = (s4_pay_ff.rms[30:0] == 31'h7fff_ffff) ? 31'h7fff_ffff
            : s4_pay_ff.rms[30:0] + 1'b1;
      rad = {1'b0, d, 24'd0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pay_ff  <= s1_pay_in;
         s1_gsq_ff  <= s1_gsq_in;
         s1_p90_ff  <= s1_p90_in;
         s1_agp_ff  <= s1_agp_in;
         s1_g95p_ff <= s1_g95p_in;
         s2_pay_ff  <= s2_pay_in;
         s2_sq_ff   <= s2_sq_in;
         s2_p90_ff  <= s1_p90_ff;
         s3_pay_ff  <= s2_pay_ff;
         s3_p10_ff  <= s3_p10_in;
         s3_p90_ff  <= s2_p90_ff;
         s4_pay_ff  <= s4_pay_in;
      end
   end

   agwu_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (rad),
      .in_pay   (s4_pay_ff),
      .root     (sq_root),
      .out_pay  (sq_pay)
   );

   // ---------------- numerator with rounding, overflow flag ----------------
   always_comb begin
      sn_num_in = {sq_pay.gmag, 24'd0}
                  + {{(agwu_pkg::NUM_W - agwu_pkg::ROOT_W + 1){1'b0}},
                     sq_root[agwu_pkg::ROOT_W-1:1]};
      sn_pay_in     = sq_pay;
      sn_pay_in.ovf = {{(agwu_pkg::DEN_W + agwu_pkg::QUO_W - agwu_pkg::NUM_W){1'b0}},
                       sn_num_in} >= {sq_root, {agwu_pkg::QUO_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_pay_ff <= sn_pay_in;
         sn_num_ff <= sn_num_in;
         sn_den_ff <= sq_root;
      end
   end

   agwu_div u_div (
      .clock   (clock),
      .en      (adv),
      .num     (sn_num_ff),
      .den     (sn_den_ff),
      .in_pay  (sn_pay_ff),
      .quo     (dv_quo),
      .out_pay (dv_pay)
   );

   // ---------------- normalized gradient, change ----------------
   always_comb begin
      logic [31:0]        qs;
      logic signed [32:0] nq;
      qs = (dv_pay.ovf || (dv_quo > 32'h8000_0000)) ? 32'h8000_0000 : dv_quo;
      nq = dv_pay.operand[31] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
      se_nq_in = agwu_pkg::sat32(66'(nq));
   end

   assign sf_prod_in = 64'(se_pay_ff.ag) * 64'(se_nq_ff);
   assign sg_chg_in  = agwu_pkg::rescale_sat(66'(sf_pay_ff.mp) - 66'(sf_prod_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         se_pay_ff  <= dv_pay;
         se_nq_ff   <= se_nq_in;
         sf_pay_ff  <= se_pay_ff;
         sf_prod_ff <= sf_prod_in;
         sg_pay_ff  <= sf_pay_ff;
         sg_chg_ff  <= sg_chg_in;
      end
   end

   // ---------------- write-back ----------------
   always_comb begin
      logic flip;
      logic same;
      flip = (sg_chg_ff < 0 && sg_pay_ff.prev > 0) || (sg_chg_ff > 0 && sg_pay_ff.prev < 0);
      same = (sg_chg_ff < 0 && sg_pay_ff.prev < 0) || (sg_chg_ff > 0 && sg_pay_ff.prev > 0);
      fin_weight = agwu_pkg::sat32(66'(sg_pay_ff.weight) + 66'(sg_chg_ff));
      if (flip) begin
         fin_gain = sg_pay_ff.g95;
      end else if (same) begin
         fin_gain = agwu_pkg::sat32(66'(sg_pay_ff.gain) + 66'(agwu_pkg::K_005));
      end else begin
         fin_gain = sg_pay_ff.gain;
      end
      if (sg_pay_ff.cmd == agwu_pkg::CMD_LOAD) begin
         wr_data.weight = sg_pay_ff.operand;
         wr_data.rms    = agwu_pkg::ONE_Q24;
         wr_data.gain   = agwu_pkg::ONE_Q24;
         wr_data.change = '0;
      end else begin
         wr_data.weight = fin_weight;
         wr_data.rms    = sg_pay_ff.rms;
         wr_data.gain   = fin_gain;
         wr_data.change = sg_chg_ff;
      end
   end

   assign rsp_vld    = wr_en;
   assign rsp.addr   = adr_ff[LAST];
   assign rsp.weight = wr_data.weight;

endmodule

>>> src/adaptive_gain_weight_update.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// adaptive_gain_weight_update: per-weight optimizer update engine
// RMS-normalized momentum update with adaptive per-weight gain, Q8.24.
// -----------------------------------------------------------------------------
// A request loads a weight (cmd 0) or applies a gradient (cmd 1) to the entry
// at index (taken modulo the store size); every request returns exactly one
// response, in request order, carrying the index and the stored weight after
// the operation. Requests go into a 4-deep queue and issue into a 69-stage
// pipeline: store read, RMS update, a 28-stage square root, a 32-stage
// divider, the momentum product and the write-back. One request issues per
// cycle as long as its index is not already in flight and the pipeline is not
// frozen by a full response queue; a request to an index that is still in the
// pipeline waits until that earlier request has written back. The store holds
// no valid bits and needs no clearing after reset: an entry must be loaded
// before it is updated. The user must write learning_rate and momentum_coef
// only while no request is in flight; the block itself does not enforce this.
// -----------------------------------------------------------------------------
module adaptive_gain_weight_update (
   input  logic                          clock,
   input  logic                          reset,
   // request queue side
   input  logic                          push,
   output logic                          full,
   input  logic                          req_cmd,
   input  logic [15:0]                   req_index,
   input  logic signed [31:0]            req_operand_value,
   // response queue side
   output logic                          empty,
   input  logic                          pop,
   output logic [15:0]                   rsp_out_index,
   output logic signed [31:0]            rsp_new_weight,
   // configuration
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [agwu_pkg::CFG_W-1:0]    csr_wdata
);

   logic [agwu_pkg::CFG_W-1:0]       lr_ff;
   logic [agwu_pkg::CFG_W-1:0]       mom_ff;

   logic                             head_vld;
   agwu_pkg::req_type                head;
   logic                             take;

   logic                             out_full;
   logic                             bk_vld;
   agwu_pkg::rsp_type                bk_rsp;

   // response skid queue
   agwu_pkg::rsp_type                oq_ff [agwu_pkg::OQ_DEPTH];
   logic [agwu_pkg::OQ_PTR_W-1:0]    oq_wr_ff, oq_wr_in;
   logic [agwu_pkg::OQ_PTR_W-1:0]    oq_rd_ff, oq_rd_in;
   logic [agwu_pkg::OQ_CNT_W-1:0]    oq_cnt_ff, oq_cnt_in;
   logic                             oq_pop;
   agwu_pkg::rsp_type                oq_head;

   // Configuration registers: learning rate and momentum, Q1.24
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= agwu_pkg::LR_RESET;
         mom_ff <= agwu_pkg::MOM_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            agwu_pkg::CSR_LEARNING_RATE: lr_ff  <= csr_wdata;
            agwu_pkg::CSR_MOMENTUM_COEF: mom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front: intake and index mapping
   agwu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_operand_value (req_operand_value),
      .head_vld          (head_vld),
      .head              (head),
      .take              (take)
   );

   // Back: hazard-checked issue, arithmetic pipeline, store write-back
   agwu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .learning_rate (lr_ff),
      .momentum_coef (mom_ff),
      .head_vld      (head_vld),
      .head          (head),
      .take          (take),
      .out_full      (out_full),
      .rsp_vld       (bk_vld),
      .rsp           (bk_rsp)
   );

   // Response queue: the pipeline freezes only when this is full and the
   // last stage holds a finished request.
   assign out_full = (oq_cnt_ff == agwu_pkg::OQ_FULL);
   assign empty    = (oq_cnt_ff == '0);
   assign oq_pop   = pop && !empty;
   assign oq_head  = oq_ff[oq_rd_ff];

   assign rsp_out_index  = agwu_pkg::to_index(oq_head.addr);
   assign rsp_new_weight = oq_head.weight;

   always_comb begin
      oq_wr_in  = oq_wr_ff;
      oq_rd_in  = oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (bk_vld) begin
         oq_wr_in = (oq_wr_ff == agwu_pkg::OQ_LAST) ? '0 : oq_wr_ff + 1'b1;
      end
      if (oq_pop) begin
         oq_rd_in = (oq_rd_ff == agwu_pkg::OQ_LAST) ? '0 : oq_rd_ff + 1'b1;
      end
      if (bk_vld && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_pop && !bk_vld) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bk_vld) begin
         oq_ff[oq_wr_ff] <= bk_rsp;
      end
   end

endmodule

>>> dv/agwu_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// agwu_checker: response predictor and scoreboard
// Watches both queues and the register port, predicts each stored weight in
// Q8.24 and compares every popped response with the oldest prediction.
// -----------------------------------------------------------------------------
module agwu_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic                           req_cmd,
   input  logic [15:0]                    req_index,
   input  logic signed [31:0]             req_operand_value,
   input  logic                           empty,
   input  logic                           pop,
   input  logic [15:0]                    rsp_out_index,
   input  logic signed [31:0]             rsp_new_weight,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [agwu_pkg::CFG_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);

   typedef struct {
      logic [15:0]        idx;
      logic signed [31:0] weight;
   } weight_result_type;

   logic signed [31:0]          weight_mem [agwu_pkg::NUM_WEIGHTS];
   logic signed [31:0]          msq_mem    [agwu_pkg::NUM_WEIGHTS];
   logic signed [31:0]          gain_mem   [agwu_pkg::NUM_WEIGHTS];
   logic signed [31:0]          chg_mem    [agwu_pkg::NUM_WEIGHTS];
   logic [agwu_pkg::CFG_W-1:0]  step_size;
   logic [agwu_pkg::CFG_W-1:0]  mom_factor;
   weight_result_type           weight_fifo[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // divide by 2^24, round half away from zero
   function automatic longint round_q24(input longint v);
      longint unsigned m;
      longint          r;
      m = (v < 0) ? longint'(-v) : longint'(v);
      r = longint'((m + 64'd8388608) >> 24);
      return (v < 0) ? -r : r;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // applies one request to the shadow stores, returns the stored weight
   function automatic logic signed [31:0] predict_weight(input logic cmd,
         input logic [15:0] a, input logic signed [31:0] opnd);
      longint          g, msq, gain, prev, w, acc, msq_new, d, nq, ag, chg;
      longint unsigned gmag, sq, s, q;
      g = opnd;
      if (cmd == agwu_pkg::CMD_LOAD) begin
         weight_mem[a] = opnd;
         msq_mem[a]    = agwu_pkg::ONE_Q24;
         gain_mem[a]   = agwu_pkg::ONE_Q24;
         chg_mem[a]    = '0;
         return opnd;
      end
      msq  = msq_mem[a];
      gain = gain_mem[a];
      prev = chg_mem[a];
      w    = weight_mem[a];
      gmag = (g < 0) ? longint'(-g) : longint'(g);
      sq   = (gmag * gmag + 64'd8388608) >> 24;
      if (sq > 64'd2147483647) sq = 64'd2147483647;
      acc = longint'(agwu_pkg::K_090) * msq + longint'(agwu_pkg::K_010) * longint'(sq);
      if (acc < 0) acc = 0;
      msq_new = clamp32(round_q24(acc));
      d = msq_new + 1;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      s = int_root(longint'(d) << 24);
      q = ((gmag << 24) + s / 2) / s;
      if (q > 64'd2147483648) q = 64'd2147483648;
      nq  = clamp32((g < 0) ? -longint'(q) : longint'(q));
      ag  = clamp32(round_q24(longint'(step_size) * gain));
      chg = clamp32(round_q24(longint'(mom_factor) * prev - ag * nq));
      w   = clamp32(w + chg);
      // gain shrinks on a sign flip, grows while the direction holds
      if ((chg < 0 && prev > 0) || (chg > 0 && prev < 0))
         gain = clamp32(round_q24(gain * longint'(agwu_pkg::K_095)));
      else if ((chg < 0 && prev < 0) || (chg > 0 && prev > 0))
         gain = clamp32(gain + longint'(agwu_pkg::K_005));
      msq_mem[a]    = msq_new;
      chg_mem[a]    = chg;
      weight_mem[a] = w;
      gain_mem[a]   = gain;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
         input longint want);
      $display("%0t ns: %s mismatch: got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      weight_result_type r;
      if (reset) begin
         step_size  = agwu_pkg::LR_RESET;
         mom_factor = agwu_pkg::MOM_RESET;
      end else begin
         if (csr_write_en) begin
            if (csr_index == agwu_pkg::CSR_LEARNING_RATE) step_size = csr_wdata;
            else if (csr_index == agwu_pkg::CSR_MOMENTUM_COEF) mom_factor = csr_wdata;
         end
         if (push && !full) begin
            r.idx    = req_index;
            r.weight = predict_weight(req_cmd, req_index, req_operand_value);
            weight_fifo = {weight_fifo, r};
         end
         if (pop && !empty) begin
            if (weight_fifo.size() == 0) begin
               report_mismatch("unrequested response", rsp_out_index, -1);
            end else begin
               r = weight_fifo.pop_front();
               if (rsp_out_index !== r.idx)
                  report_mismatch("out_index", rsp_out_index, r.idx);
               if (rsp_new_weight !== r.weight)
                  report_mismatch("new_weight", rsp_new_weight, r.weight);
            end
         end
      end
      outstanding = weight_fifo.size();
   end

endmodule

>>> dv/adaptive_gain_weight_update_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// adaptive_gain_weight_update_tb: testbench top for the weight update engine
// Directed loads/updates, then four random phases with different register
// settings and idle/stall mixes; agwu_checker predicts and scores responses.
// -----------------------------------------------------------------------------
module adaptive_gain_weight_update_tb;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic                         req_cmd = agwu_pkg::CMD_LOAD;
   logic [15:0]                  req_index = '0;
   logic signed [31:0]           req_operand_value = '0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic [15:0]                  rsp_out_index;
   logic signed [31:0]           rsp_new_weight;
   logic                         csr_write_en = 1'b0;
   logic                         csr_index = agwu_pkg::CSR_LEARNING_RATE;
   logic [agwu_pkg::CFG_W-1:0]   csr_wdata = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;   // chance of a sender gap in a cycle
   int stall_pct = 0;       // chance the receiver holds pop low
   int loaded_pool[$];      // indexes that hold a loaded weight

   always #6 clock = ~clock;

   adaptive_gain_weight_update uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_cmd(req_cmd), .req_index(req_index), .req_operand_value(req_operand_value),
      .empty(empty), .pop(pop),
      .rsp_out_index(rsp_out_index), .rsp_new_weight(rsp_new_weight),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   agwu_checker u_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_cmd(req_cmd), .req_index(req_index), .req_operand_value(req_operand_value),
      .empty(empty), .pop(pop),
      .rsp_out_index(rsp_out_index), .rsp_new_weight(rsp_new_weight),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // receiver: random pop stalls, driven on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #(12 * 800000);
      $display("adaptive_gain_weight_update_tb: FAIL");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic cmd, input logic [15:0] idx,
         input logic signed [31:0] opnd);
      logic was_full;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push              <= 1'b1;
      req_cmd           <= cmd;
      req_index         <= idx;
      req_operand_value <= opnd;
      do begin
         was_full = full;   // full only moves at the rising edge
         @(negedge clock);
      end while (was_full);
   endtask

   task automatic load_weight(input logic [15:0] idx, input logic signed [31:0] w);
      int hit;
      send_request(agwu_pkg::CMD_LOAD, idx, w);
      hit = 0;
      foreach (loaded_pool[i]) if (loaded_pool[i] == idx) hit = 1;
      if (!hit) begin
         if (loaded_pool.size() < 48) loaded_pool = {loaded_pool, int'(idx)};
         else loaded_pool[$urandom_range(47)] = int'(idx);
      end
   endtask

   // drop push and let every response drain, plus the pipeline depth
   task automatic drain_all;
      push <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (agwu_pkg::PIPE_DEPTH + 10) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [agwu_pkg::CFG_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_gradient;
      if ($urandom_range(7) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
   endfunction

   initial begin
      logic [agwu_pkg::CFG_W-1:0] lr_set [4];
      logic [agwu_pkg::CFG_W-1:0] mom_set [4];
      int idle_set [4];
      int stall_set [4];
      int idx;

      lr_set    = '{25'd16777216, 25'd0, 25'd0, 25'd16777};
      mom_set   = '{25'd0, 25'd16777216, 25'd0, 25'd0};
      idle_set  = '{0, 55, 0, 22};
      stall_set = '{0, 0, 55, 22};
      lr_set[2]  = 25'($urandom_range(0, 16777216));
      mom_set[2] = 25'($urandom_range(0, 16777216));
      mom_set[3] = 25'($urandom_range(0, 16777216));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: index extremes, weight extremes, gradient extremes
      load_weight(16'd0, 32'sh7fff_ffff);
      load_weight(16'hffff, 32'sh8000_0000);
      load_weight(16'h5a5a, 32'sd0);
      send_request(agwu_pkg::CMD_UPDATE, 16'd0, 32'sh7fff_ffff);
      send_request(agwu_pkg::CMD_UPDATE, 16'hffff, 32'sh8000_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h5a5a, 32'sd0);
      send_request(agwu_pkg::CMD_UPDATE, 16'h5a5a, 32'sd1);
      send_request(agwu_pkg::CMD_UPDATE, 16'h5a5a, -32'sd1);
      // same sign twice grows the gain, then a flip shrinks it
      load_weight(16'h00a5, 32'sh0100_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, 32'sh0080_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, 32'sh0080_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, -32'sh0400_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, -32'sh0400_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, 32'sh7000_0000);
      // reload resets the entry's history
      load_weight(16'h00a5, -32'sh0300_0000);
      send_request(agwu_pkg::CMD_UPDATE, 16'h00a5, 32'sh0000_1000);
      drain_all();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(agwu_pkg::CSR_LEARNING_RATE, lr_set[ph]);
         write_reg(agwu_pkg::CSR_MOMENTUM_COEF, mom_set[ph]);
         send_idle_pct = idle_set[ph];
         stall_pct     = stall_set[ph];
         for (int n = 0; n < 210; n++) begin
            if (ph == 1 && n == 100) drain_all();   // sender holds until all is back
            if ($urandom_range(99) < 15 || loaded_pool.size() == 0) begin
               if ($urandom_range(2) == 0 && loaded_pool.size() != 0)
                  idx = loaded_pool[$urandom_range(loaded_pool.size() - 1)];
               else
                  idx = $urandom_range(0, 65535);
               if ($urandom_range(3) == 0)
                  load_weight(16'(idx), $urandom);
               else
                  load_weight(16'(idx), $signed($urandom_range(0, 32'h0800_0000))
                                        - 32'sh0400_0000);
            end else begin
               idx = loaded_pool[$urandom_range(loaded_pool.size() - 1)];
               send_request(agwu_pkg::CMD_UPDATE, 16'(idx), rand_gradient());
            end
         end
         drain_all();
      end

      if (fail_count == 0) begin
         $display("adaptive_gain_weight_update_tb: PASS");
      end else begin
         $display("adaptive_gain_weight_update_tb: FAIL");
      end
      $finish;
   end

endmodule
